[sv/prc_pkg.sv]
// Shared types, widths and constant tables for the polar/rectangular converter.
// Tables (CORDIC angles in Q32 degrees, gain in Q31) are built at elaboration.
// No dependencies.
package prc_pkg;

  localparam int STEPS     = 16;
  localparam int FRAC_BITS = 16;
  localparam int STEP_W    = $clog2(STEPS);

  // Port field widths.
  localparam int A_W   = 32;
  localparam int B_W   = 26;
  localparam int X_W   = 32;
  localparam int MAG_W = 32;
  localparam int ANG_W = 25;

  // Internal widths.
  localparam int AX_W     = A_W + 1;      // coord_a after mirroring
  localparam int BX_W     = B_W + 1;      // coord_b after mirroring / angle sums
  localparam int DW       = 64;           // rotation datapath
  localparam int ZW       = 40;           // residual angle, Q32 degrees
  localparam int GAIN_W   = 31;           // gain in Q31
  localparam int Z_SHIFT  = 32 - FRAC_BITS;
  localparam int PRESCALE = 30;
  localparam int MAG_SHIFT = 61;
  localparam int LATENCY  = STEPS + 5;

  localparam logic signed [BX_W-1:0] DEG90  = BX_W'(90 <<< FRAC_BITS);
  localparam logic signed [BX_W-1:0] DEG180 = BX_W'(180 <<< FRAC_BITS);
  localparam logic signed [BX_W-1:0] DEG360 = BX_W'(360 <<< FRAC_BITS);

  typedef enum logic {
    OP_P2R = 1'b0,
    OP_R2P = 1'b1
  } op_e;

  typedef struct packed {
    op_e  op;
    logic flip;      // half turn (polar input) or mirror through origin (rect input)
    logic base_neg;  // mirror base is -180 instead of +180
    logic zero;      // rect input with both coordinates zero
  } meta_t;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [ZW-1:0] z;
    meta_t                meta;
  } rot_t;

  typedef logic [STEPS-1:0][ZW-1:0] angle_tab_t;

  // 180/pi in Q56, floored.
  localparam logic [127:0] DEG_Q_WIDE =
      (128'd572957795130823 << 56) / 128'd10000000000000;
  localparam logic [63:0]  DEG_Q = DEG_Q_WIDE[63:0];

  // Restoring division, used only while building the tables.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem    = rem - {1'b0, d};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bitv;
    n    = n_in;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int s = 0; s < 32; s++) begin
      if (bitv > n) bitv = bitv >> 2;
    end
    for (int s = 0; s < 32; s++) begin
      if (bitv != '0) begin
        if (n >= res + bitv) begin
          n   = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

  // atan(2^-i) in Q32 degrees: odd power series in Q62 radians, scaled by 180/pi.
  function automatic angle_tab_t build_angle_tab();
    angle_tab_t   tab;
    logic [63:0]  acc;
    logic [63:0]  term;
    logic [127:0] prod;
    tab = '0;
    for (int i = 0; i < STEPS; i++) begin
      if (i == 0) begin
        tab[i] = ZW'(64'd45 << 32);
      end else begin
        acc = '0;
        for (int k = 1; i * k <= 62; k += 2) begin
          term = udiv64(64'd1 << (62 - i * k), 64'(k));
          if (((k >> 1) & 1) != 0) acc = acc - term;
          else acc = acc + term;
        end
        prod   = 128'(acc) * 128'(DEG_Q) + (128'd1 << 85);
        tab[i] = ZW'(prod >> 86);
      end
    end
    return tab;
  endfunction

  function automatic logic [63:0] build_gain();
    logic [63:0] k2;
    k2 = 64'd1 << 62;
    for (int i = 0; i < STEPS; i++) begin
      if (2 * i <= 62) k2 = k2 - udiv64(k2, (64'd1 << (2 * i)) + 64'd1);
    end
    return isqrt64(k2);
  endfunction

  localparam angle_tab_t  ANGLE_TAB = build_angle_tab();
  localparam logic [63:0] GAIN_WIDE = build_gain();
  localparam logic [GAIN_W-1:0] GAIN = GAIN_WIDE[GAIN_W-1:0];

endpackage

[sv/prc_front.sv]
// Input side of the converter: angle reduction or mirroring, then prescale (gain multiply or shift).
// Two registered stages feeding the rotation chain. Depends on prc_pkg.
module prc_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             op_i,
  input  logic signed [prc_pkg::A_W-1:0]   coord_a_i,
  input  logic signed [prc_pkg::B_W-1:0]   coord_b_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output prc_pkg::rot_t                    data_o
);
  import prc_pkg::*;

  logic signed [AX_W-1:0] a_ext, a_d, a_q;
  logic signed [BX_W-1:0] b_ext, b_d, b_q;
  logic signed [BX_W-1:0] r_mod, r_half, r_fold;
  logic signed [ZW-1:0]   z_d, z_q;
  logic                   fold;
  op_e                    op_in;
  meta_t                  meta_d, meta_q;
  logic                   a_valid_q, a_ready;
  logic                   b_valid_q, b_ready;
  logic signed [AX_W+32-1:0] prod;
  rot_t                   rot_d, rot_q;

  assign b_ready    = !b_valid_q || ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  always_comb begin
    op_in = op_e'(op_i);
    a_ext = {coord_a_i[A_W-1], coord_a_i};
    b_ext = {coord_b_i[B_W-1], coord_b_i};

    // The input never reaches two full turns, so one correction does the modulo.
    r_mod = b_ext;
    if (b_ext >= DEG360) r_mod = b_ext - DEG360;
    else if (b_ext <= -DEG360) r_mod = b_ext + DEG360;

    r_half = r_mod;
    if (r_mod > DEG180) r_half = r_mod - DEG360;
    else if (r_mod < -DEG180) r_half = r_mod + DEG360;

    r_fold = r_half;
    fold   = 1'b0;
    if (r_half > DEG90) begin
      r_fold = r_half - DEG180;
      fold   = 1'b1;
    end else if (r_half < -DEG90) begin
      r_fold = r_half + DEG180;
      fold   = 1'b1;
    end

    meta_d    = '0;
    meta_d.op = op_in;
    if (op_in == OP_P2R) begin
      a_d         = a_ext;
      b_d         = '0;
      z_d         = {{(ZW-BX_W){r_fold[BX_W-1]}}, r_fold} << Z_SHIFT;
      meta_d.flip = fold;
    end else begin
      meta_d.zero     = (coord_a_i == '0) && (coord_b_i == '0);
      meta_d.flip     = a_ext[AX_W-1];
      meta_d.base_neg = b_ext[BX_W-1];
      a_d             = a_ext[AX_W-1] ? -a_ext : a_ext;
      b_d             = a_ext[AX_W-1] ? -b_ext : b_ext;
      z_d             = '0;
    end
  end

  always_comb begin
    prod       = $signed(a_q) * $signed({1'b0, GAIN});
    rot_d.meta = meta_q;
    rot_d.z    = z_q;
    if (meta_q.op == OP_P2R) begin
      rot_d.x = prod[DW-1:0];
      rot_d.y = '0;
    end else begin
      rot_d.x = {{(DW-AX_W){a_q[AX_W-1]}}, a_q} << PRESCALE;
      rot_d.y = {{(DW-BX_W){b_q[BX_W-1]}}, b_q} << PRESCALE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= in_valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_q    <= a_d;
      b_q    <= b_d;
      z_q    <= z_d;
      meta_q <= meta_d;
    end
    if (b_ready && a_valid_q) begin
      rot_q <= rot_d;
    end
  end

  assign valid_o = b_valid_q;
  assign data_o  = rot_q;

endmodule

[sv/prc_cell.sv]
// One CORDIC micro-rotation stage with its own handshake register.
// The step index selects the shift and the angle table entry. Depends on prc_pkg.
module prc_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [prc_pkg::STEP_W-1:0]  step_i,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  prc_pkg::rot_t               data_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output prc_pkg::rot_t               data_o
);
  import prc_pkg::*;

  logic                 valid_q;
  logic                 pos;
  logic signed [DW-1:0] x_sh, y_sh;
  logic signed [ZW-1:0] ang;
  rot_t                 data_d, data_q;

  assign ready_o = !valid_q || ready_i;

  // Polar input steers by the residual angle, rectangular input by the sign of y.
  // Both conventions reduce to the same update once the direction is known.
  always_comb begin
    pos    = (data_i.meta.op == OP_R2P) ? ($signed(data_i.y) <= 0)
                                        : ($signed(data_i.z) >= 0);
    x_sh   = $signed(data_i.x) >>> step_i;
    y_sh   = $signed(data_i.y) >>> step_i;
    ang    = $signed(ANGLE_TAB[step_i]);
    data_d = data_i;
    if (pos) begin
      data_d.x = data_i.x - y_sh;
      data_d.y = data_i.y + x_sh;
      data_d.z = data_i.z - ang;
    end else begin
      data_d.x = data_i.x + y_sh;
      data_d.y = data_i.y - x_sh;
      data_d.z = data_i.z + ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  // Vectoring starts in the right half plane and only ever grows x.
  a_vec_x_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (data_q.meta.op == OP_R2P) |-> !data_q.x[DW-1])
    else $error("vectoring x went negative");

endmodule

[sv/prc_back.sv]
// Output side: gain multiply for the length (split in two partial products),
// rounding, saturation and the output register. Depends on prc_pkg.
module prc_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  prc_pkg::rot_t                     data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [prc_pkg::X_W-1:0]    x_out_o,
  output logic signed [prc_pkg::X_W-1:0]    y_out_o,
  output logic [prc_pkg::MAG_W-1:0]         magnitude_o,
  output logic signed [prc_pkg::ANG_W-1:0]  angle_deg_o
);
  import prc_pkg::*;

  localparam int PW    = 2 * GAIN_W;
  localparam int SUM_W = PW + GAIN_W + 1;

  localparam logic signed [X_W+1:0] I32_MAX = (X_W+2)'((64'sd1 <<< 31) - 64'sd1);
  localparam logic signed [X_W+1:0] I32_MIN = -((X_W+2)'(64'sd1 <<< 31));

  logic                 v1_q, v2_q, v3_q;
  logic                 rdy1, rdy2, rdy3;
  rot_t                 r1_q, r2_q;
  logic [PW-1:0]        pl_d, pl1_q, pl2_q, ph_d, ph_q;

  logic [SUM_W-1:0]        mag_sum;
  logic [MAG_W:0]          mag_raw;
  logic signed [ZW-1:0]    z_rnd;
  logic signed [BX_W-1:0]  ang_sum;
  logic signed [X_W-1:0]   x_d, y_d;
  logic [MAG_W-1:0]        mag_d;
  logic signed [ANG_W-1:0] ang_d;

  logic signed [X_W-1:0]   x_q, y_q;
  logic [MAG_W-1:0]        mag_q;
  logic signed [ANG_W-1:0] ang_q;

  // Round Q(F+31) to Q(F), undo the half turn, saturate to 32 bits.
  function automatic logic signed [X_W-1:0] round_sat(input logic signed [DW-1:0] v,
                                                       input logic flip);
    logic signed [DW-1:0]  vr;
    logic signed [X_W+1:0] w;
    vr = v + (DW'(1) << (GAIN_W - 1));
    w  = {vr[DW-1], vr[DW-1:GAIN_W]};
    if (flip) w = -w;
    if (w > I32_MAX) return X_W'(I32_MAX);
    if (w < I32_MIN) return X_W'(I32_MIN);
    return w[X_W-1:0];
  endfunction

  assign rdy3    = !v3_q || out_ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  assign pl_d = {{GAIN_W{1'b0}}, data_i.x[GAIN_W-1:0]} * {{GAIN_W{1'b0}}, GAIN};
  assign ph_d = {{GAIN_W{1'b0}}, r1_q.x[2*GAIN_W-1:GAIN_W]} * {{GAIN_W{1'b0}}, GAIN};

  always_comb begin
    mag_sum = {1'b0, ph_q, {GAIN_W{1'b0}}} + SUM_W'(pl2_q) + (SUM_W'(1) << (MAG_SHIFT - 1));
    mag_raw = mag_sum[SUM_W-1:MAG_SHIFT];

    z_rnd   = r2_q.z + (ZW'(1) << (Z_SHIFT - 1));
    ang_sum = {{(BX_W-(ZW-Z_SHIFT)){z_rnd[ZW-1]}}, z_rnd[ZW-1:Z_SHIFT]};
    if (r2_q.meta.flip) ang_sum = r2_q.meta.base_neg ? ang_sum - DEG180 : ang_sum + DEG180;
    if (ang_sum > DEG180) ang_sum = DEG180;
    else if (ang_sum < -DEG180) ang_sum = -DEG180;

    x_d   = '0;
    y_d   = '0;
    mag_d = '0;
    ang_d = '0;
    if (r2_q.meta.op == OP_P2R) begin
      x_d = round_sat(r2_q.x, r2_q.meta.flip);
      y_d = round_sat(r2_q.y, r2_q.meta.flip);
    end else if (!r2_q.meta.zero) begin
      mag_d = mag_raw[MAG_W] ? '1 : mag_raw[MAG_W-1:0];
      ang_d = ang_sum[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      r1_q  <= data_i;
      pl1_q <= pl_d;
    end
    if (rdy2 && v1_q) begin
      r2_q  <= r1_q;
      pl2_q <= pl1_q;
      ph_q  <= ph_d;
    end
    if (rdy3 && v2_q) begin
      x_q   <= x_d;
      y_q   <= y_d;
      mag_q <= mag_d;
      ang_q <= ang_d;
    end
  end

  assign out_valid_o = v3_q;
  assign x_out_o     = x_q;
  assign y_out_o     = y_q;
  assign magnitude_o = mag_q;
  assign angle_deg_o = ang_q;

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> ($signed(ang_q) <= DEG180) && ($signed(ang_q) >= -DEG180))
    else $error("angle outside half turn");

  a_fields_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && ((x_q != '0) || (y_q != '0)) |-> (mag_q == '0) && (ang_q == '0))
    else $error("rectangular and polar results both set");

endmodule

[sv/polar_rect_converter_unit.sv]
// Top level of the polar/rectangular converter: front stages, CORDIC cell chain, back end.
// Depends on prc_pkg, prc_front, prc_cell and prc_back.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_ready_o   op_i, coord_a_i, coord_b_i
//   out      source     out_valid_o / out_ready_i x_out_o, y_out_o, magnitude_o, angle_deg_o
//
// One beat per cycle sustained while the output is not stalled; the stages are two front stages,
// one per rotation cell, two gain-multiply stages and the output register.
// Every stage holds one beat and takes a new one when it is empty or its successor moves,
// so a stalled output only backs up the chain as far as it is full.
// Reset clears the valid bits of all stages; payload registers are not reset.
module polar_rect_converter_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             op_i,
  input  logic signed [prc_pkg::A_W-1:0]   coord_a_i,
  input  logic signed [prc_pkg::B_W-1:0]   coord_b_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [prc_pkg::X_W-1:0]   x_out_o,
  output logic signed [prc_pkg::X_W-1:0]   y_out_o,
  output logic [prc_pkg::MAG_W-1:0]        magnitude_o,
  output logic signed [prc_pkg::ANG_W-1:0] angle_deg_o
);
  import prc_pkg::*;

  localparam int CNT_W = $clog2(LATENCY + 1);

  logic [STEPS:0] chain_valid;
  logic [STEPS:0] chain_ready;
  rot_t           chain_data [STEPS+1];
  logic [CNT_W-1:0] occ_q;
  logic             in_acc, out_acc;

  prc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .coord_a_i  (coord_a_i),
    .coord_b_i  (coord_b_i),
    .valid_o    (chain_valid[0]),
    .ready_i    (chain_ready[0]),
    .data_o     (chain_data[0])
  );

  for (genvar g = 0; g < STEPS; g++) begin : g_cell
    prc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (STEP_W'(g)),
      .valid_i (chain_valid[g]),
      .ready_o (chain_ready[g]),
      .data_i  (chain_data[g]),
      .valid_o (chain_valid[g+1]),
      .ready_i (chain_ready[g+1]),
      .data_o  (chain_data[g+1])
    );
  end

  prc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (chain_valid[STEPS]),
    .ready_o     (chain_ready[STEPS]),
    .data_i      (chain_data[STEPS]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .x_out_o     (x_out_o),
    .y_out_o     (y_out_o),
    .magnitude_o (magnitude_o),
    .angle_deg_o (angle_deg_o)
  );

  // Beats in flight, kept for the checks below.
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (in_acc && !out_acc) begin
      occ_q <= occ_q + CNT_W'(1);
    end else if (!in_acc && out_acc) begin
      occ_q <= occ_q - CNT_W'(1);
    end
  end

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(LATENCY))
    else $error("more beats in flight than pipeline stages");

  a_out_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (occ_q != '0))
    else $error("output beat without a matching input beat");

endmodule

[dv/polar_rect_converter_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for polar_rect_converter_unit: directed and random conversions
// in both directions, checked beat by beat against a bit-exact CORDIC predictor.
// Depends on prc_pkg and the converter RTL.
module polar_rect_converter_unit_tb;
  import prc_pkg::*;

  localparam int     DEG             = 1 << FRAC_BITS;
  localparam int     B_LIMIT         = 360 * DEG;
  localparam int     SETTLE_CYCLES   = 32;
  localparam int     WATCHDOG_LIMIT  = 4000;
  localparam int     RANDOM_VECTORS  = 900;
  localparam longint Q32_90          = 64'sd90 <<< 32;
  localparam longint Q32_180         = 64'sd180 <<< 32;
  localparam longint Q32_360         = 64'sd360 <<< 32;
  localparam longint INT32_LO        = -(64'sd1 <<< 31);
  localparam longint INT32_HI        = (64'sd1 <<< 31) - 1;
  localparam longint MAG_MAX         = 64'h0000_0000_FFFF_FFFF;
  localparam longint ANG_HALF_TURN   = 64'sd180 <<< FRAC_BITS;
  localparam longint ANG_FIELD_LO    = -(64'sd1 <<< (ANG_W - 1));
  localparam longint ANG_FIELD_HI    = (64'sd1 <<< (ANG_W - 1)) - 1;

  typedef enum int {
    READY_ALWAYS,
    READY_HALF,
    READY_SPARSE,
    READY_BURSTY
  } ready_mode_e;

  typedef struct packed {
    logic signed [X_W-1:0]   x;
    logic signed [X_W-1:0]   y;
    logic [MAG_W-1:0]        mag;
    logic signed [ANG_W-1:0] ang;
  } conversion_t;

  class conversion_scoreboard;
    longint      atan_deg_q32[STEPS];
    logic [63:0] gain_q31;
    conversion_t pending_q[$];
    int          errors;

    // Arctangent table in Q32 degrees and the CORDIC gain in Q31.
    function new();
      logic [127:0] deg_q;
      logic [127:0] prod;
      logic [63:0]  acc;
      logic [63:0]  term;
      logic [63:0]  k2;
      logic [63:0]  trial;
      errors = 0;
      deg_q  = (128'd572957795130823 << 56) / 128'd10000000000000;
      for (int i = 0; i < STEPS; i++) begin
        if (i == 0) begin
          atan_deg_q32[i] = 64'sd45 <<< 32;
        end else begin
          acc = '0;
          // Odd power series of atan(2^-i) in Q62 radians.
          for (int k = 1; i * k <= 62; k += 2) begin
            term = (64'd1 << (62 - i * k)) / 64'(k);
            if (k % 4 == 3) acc = acc - term;
            else acc = acc + term;
          end
          prod = {64'd0, acc} * deg_q + (128'd1 << 85);
          atan_deg_q32[i] = longint'(prod >> 86);
        end
      end
      k2 = 64'd1 << 62;
      for (int i = 0; i < STEPS; i++) begin
        if (2 * i <= 62) k2 = k2 - k2 / ((64'd1 << (2 * i)) + 64'd1);
      end
      gain_q31 = '0;
      for (int b = 31; b >= 0; b--) begin
        trial = gain_q31 | (64'd1 << b);
        if (trial * trial <= k2) gain_q31 = trial;
      end
    endfunction

    function conversion_t convert_vector(input logic op, input logic signed [A_W-1:0] a,
                                         input logic signed [B_W-1:0] b);
      conversion_t  r;
      longint       x, y, z, dx, dy, base, xo, yo, mag, ang;
      logic         neg;
      logic [63:0]  x_u;
      logic [127:0] prod;
      r   = '0;
      neg = 1'b0;
      if (op == OP_P2R) begin
        z = longint'(b) * (64'sd1 <<< (32 - FRAC_BITS));
        z = z % Q32_360;
        if (z > Q32_180) z = z - Q32_360;
        if (z < -Q32_180) z = z + Q32_360;
        // Fold into the right half plane; a half turn negates the result.
        if (z > Q32_90) begin
          z   = z - Q32_180;
          neg = 1'b1;
        end else if (z < -Q32_90) begin
          z   = z + Q32_180;
          neg = 1'b1;
        end
        x = longint'(a) * longint'(gain_q31);
        y = 0;
        for (int i = 0; i < STEPS; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - atan_deg_q32[i];
          end else begin
            x = x + dx;
            y = y - dy;
            z = z + atan_deg_q32[i];
          end
        end
        xo = (x + (64'sd1 <<< 30)) >>> 31;
        yo = (y + (64'sd1 <<< 30)) >>> 31;
        if (neg) begin
          xo = -xo;
          yo = -yo;
        end
        if (xo < INT32_LO) xo = INT32_LO;
        if (xo > INT32_HI) xo = INT32_HI;
        if (yo < INT32_LO) yo = INT32_LO;
        if (yo > INT32_HI) yo = INT32_HI;
        r.x = X_W'(xo);
        r.y = X_W'(yo);
      end else begin
        x = longint'(a);
        y = longint'(b);
        if (x != 0 || y != 0) begin
          base = 0;
          // Left half plane: mirror through the origin and add a half turn afterwards.
          if (x < 0) begin
            base = (y >= 0) ? ANG_HALF_TURN : -ANG_HALF_TURN;
            x    = -x;
            y    = -y;
          end
          x = x <<< 30;
          y = y <<< 30;
          z = 0;
          for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
              x = x + dx;
              y = y - dy;
              z = z + atan_deg_q32[i];
            end else begin
              x = x - dx;
              y = y + dy;
              z = z - atan_deg_q32[i];
            end
          end
          x_u  = x;
          prod = {64'd0, x_u} * {64'd0, gain_q31} + (128'd1 << 60);
          mag  = $signed(prod[124:61]);
          if (mag < 0) mag = 0;
          if (mag > MAG_MAX) mag = MAG_MAX;
          ang = ((z + (64'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS)) + base;
          if (ang < -ANG_HALF_TURN) ang = -ANG_HALF_TURN;
          if (ang > ANG_HALF_TURN) ang = ANG_HALF_TURN;
          if (ang < ANG_FIELD_LO) ang = ANG_FIELD_LO;
          if (ang > ANG_FIELD_HI) ang = ANG_FIELD_HI;
          r.mag = MAG_W'(mag);
          r.ang = ANG_W'(ang);
        end
      end
      return r;
    endfunction

    function void note_vector(input logic op, input logic signed [A_W-1:0] a,
                              input logic signed [B_W-1:0] b);
      pending_q.push_back(convert_vector(op, a, b));
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function void check_result(input logic signed [X_W-1:0] x, input logic signed [X_W-1:0] y,
                               input logic [MAG_W-1:0] mag,
                               input logic signed [ANG_W-1:0] ang);
      conversion_t e;
      if (pending_q.size() == 0) begin
        $error("result beat with no conversion pending");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (x !== e.x) begin
        $error("x_out mismatch: expected %0d, actual %0d", e.x, x);
        errors++;
      end
      if (y !== e.y) begin
        $error("y_out mismatch: expected %0d, actual %0d", e.y, y);
        errors++;
      end
      if (mag !== e.mag) begin
        $error("magnitude mismatch: expected %0d, actual %0d", e.mag, mag);
        errors++;
      end
      if (ang !== e.ang) begin
        $error("angle_deg mismatch: expected %0d, actual %0d", e.ang, ang);
        errors++;
      end
    endfunction
  endclass

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  logic                    op_i        = 1'b0;
  logic signed [A_W-1:0]   coord_a_i   = '0;
  logic signed [B_W-1:0]   coord_b_i   = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [X_W-1:0]   x_out_o;
  logic signed [X_W-1:0]   y_out_o;
  logic [MAG_W-1:0]        magnitude_o;
  logic signed [ANG_W-1:0] angle_deg_o;

  conversion_scoreboard sb;
  int                   burst_left  = 0;
  int                   idle_cycles = 0;
  ready_mode_e          ready_mode  = READY_ALWAYS;
  int                   mode_left   = 0;
  int                   stall_left  = 0;
  logic signed [A_W-1:0] a_edges[5] = '{32'sd0, 32'sd1, -32'sd1, 32'h7FFF_FFFF, 32'h8000_0000};

  polar_rect_converter_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .coord_a_i   (coord_a_i),
    .coord_b_i   (coord_b_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .x_out_o     (x_out_o),
    .y_out_o     (y_out_o),
    .magnitude_o (magnitude_o),
    .angle_deg_o (angle_deg_o)
  );

  always #1 clk_i = ~clk_i;

  // Receiver backpressure: one of four modes, picked anew at random whenever its run ends.
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      mode_left  = $urandom_range(50, 300);
    end
    mode_left--;
    case (ready_mode)
      READY_ALWAYS: out_ready_i <= 1'b1;
      READY_HALF:   out_ready_i <= ($urandom_range(0, 1) == 1);
      READY_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(5, 40);
        end
      end
    endcase
  end

  // Beats are taken from pre-edge values, so the monitor does not race the drivers.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_vector(op_i, coord_a_i, coord_b_i);
      if (out_valid_o && out_ready_i)
        sb.check_result(x_out_o, y_out_o, magnitude_o, angle_deg_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("polar_rect_converter_unit_tb failed");
          $finish;
        end
      end
    end
  end

  task automatic drive_vector(input op_e op, input int a, input int b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    op_i       <= op;
    coord_a_i  <= A_W'(a);
    coord_b_i  <= B_W'(b);
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Hold the input side idle until every pending conversion has come out.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  initial begin
    op_e                 op;
    logic signed [A_W-1:0] av;
    int                  bv;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Extremes of both fields, every quadrant and the folding boundaries.
    drive_vector(OP_P2R, 0, 0);
    drive_vector(OP_P2R, 32'h7FFF_FFFF, 0);
    drive_vector(OP_P2R, 32'h7FFF_FFFF, 90 * DEG);
    drive_vector(OP_P2R, 32'h7FFF_FFFF, -90 * DEG);
    drive_vector(OP_P2R, 32'h7FFF_FFFF, 180 * DEG);
    drive_vector(OP_P2R, 32'h8000_0000, -180 * DEG);
    drive_vector(OP_P2R, 32'h8000_0000, 0);
    drive_vector(OP_P2R, 5 * DEG, 360 * DEG);
    drive_vector(OP_P2R, 5 * DEG, -360 * DEG);
    drive_vector(OP_P2R, 100 * DEG, 45 * DEG);
    drive_vector(OP_P2R, 1, 270 * DEG);
    drive_vector(OP_P2R, -7 * DEG, 30 * DEG);
    drive_vector(OP_P2R, 1000 * DEG, -135 * DEG + 1);
    drive_vector(OP_R2P, 0, 0);
    drive_vector(OP_R2P, 32'h7FFF_FFFF, 0);
    drive_vector(OP_R2P, 32'h8000_0000, 0);
    drive_vector(OP_R2P, 32'h8000_0000, -1);
    drive_vector(OP_R2P, 0, B_LIMIT);
    drive_vector(OP_R2P, 0, -B_LIMIT);
    drive_vector(OP_R2P, -1, 0);
    drive_vector(OP_R2P, 32'h7FFF_FFFF, B_LIMIT);
    drive_vector(OP_R2P, 32'h8000_0000, -B_LIMIT);
    drive_vector(OP_R2P, 3 * DEG, 4 * DEG);
    drive_vector(OP_R2P, -1, -1);
    drain_results();

    for (int n = 0; n < RANDOM_VECTORS; n++) begin
      if (n == RANDOM_VECTORS / 2) drain_results();
      op = op_e'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0:       av = a_edges[$urandom_range(0, 4)];
        1, 2:    av = $urandom;
        3, 4, 5: av = $urandom_range(0, 1 << 20);
        default: av = $urandom_range(0, 32'h7FFF_FFFF);
      endcase
      if (op == OP_R2P && $urandom_range(0, 1) == 1) av = -av;
      case ($urandom_range(0, 9))
        // Near a multiple of a quarter turn, where the folding decisions flip.
        0: bv = int'($urandom_range(0, 8)) * 90 * DEG - B_LIMIT
                + int'($urandom_range(0, 4)) - 2;
        1, 2, 3, 4, 5: bv = int'($urandom_range(0, 2 * B_LIMIT)) - B_LIMIT;
        default: bv = int'($urandom_range(0, 2 * DEG)) - DEG;
      endcase
      if (bv > B_LIMIT) bv = B_LIMIT;
      if (bv < -B_LIMIT) bv = -B_LIMIT;
      drive_vector(op, av, bv);
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("polar_rect_converter_unit_tb passed");
    end else begin
      $display("polar_rect_converter_unit_tb failed");
    end
    $finish;
  end

endmodule

[polar_rect_converter_unit.f]
sv/prc_pkg.sv
sv/prc_front.sv
sv/prc_cell.sv
sv/prc_back.sv
sv/polar_rect_converter_unit.sv
dv/polar_rect_converter_unit_tb.sv
